// ===== rtl/core/trm_pkg.sv =====
// Shared types and constants of the throttled RMS level meter.
package trm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS   = 2'd2;

  localparam int unsigned WIN_LEN_W = 13;
  localparam int unsigned HOLDOFF_W = 16;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 13'd480;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd100;
  localparam logic [HOLDOFF_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Window result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  typedef struct packed {
    logic                 meter_enable;
    logic [WIN_LEN_W-1:0] window_len;
    logic [HOLDOFF_W-1:0] holdoff_ms;
  } cfg_t;

endpackage

// ===== rtl/core/trm_in_if.sv =====
// Input item channel: audio samples and millisecond ticks.
interface trm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

// ===== rtl/core/trm_out_if.sv =====
// Result item channel: RMS magnitude of one measured window.
interface trm_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] rms_level;

  modport source (output valid, rms_level, input ready);
  modport sink   (input valid, rms_level, output ready);
endinterface

// ===== rtl/core/throttled_rms_level_meter.sv =====
// Top level of the throttled RMS level meter: configuration registers and block wiring.
// Accepts one item (sample or millisecond tick) per cycle while the window queue has
// room. An armed window's sum of squares is handed to a back unit through a four-entry
// queue; the back unit does a restoring division by the window length and then an integer
// square root, one result at a time. Short armed windows can stall input once four
// results are pending. There is no clearing pass after reset.
module throttled_rms_level_meter #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_WINDOW  = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  trm_in_if.sink                           in_i,
  trm_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [trm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [trm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW);

  trm_pkg::cfg_t cfg_q, cfg_d;

  logic                            push;
  logic [SUM_W-1:0]                push_sum;
  logic [LEN_W-1:0]                push_len;
  logic [trm_pkg::QUEUE_CNT_W-1:0] q_count;
  logic                            q_valid;
  logic [SUM_W-1:0]                q_sum;
  logic [LEN_W-1:0]                q_len;
  logic                            pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trm_pkg::CFG_METER_ENABLE: cfg_d.meter_enable = cfg_data_i[0];
        trm_pkg::CFG_WINDOW_LEN:   cfg_d.window_len   = cfg_data_i[trm_pkg::WIN_LEN_W-1:0];
        trm_pkg::CFG_HOLDOFF_MS:   cfg_d.holdoff_ms   = cfg_data_i[trm_pkg::HOLDOFF_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.meter_enable <= 1'b0;
      cfg_q.window_len   <= trm_pkg::WIN_LEN_RESET;
      cfg_q.holdoff_ms   <= trm_pkg::HOLDOFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  trm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_kind_i   (in_i.kind),
    .in_sample_i (in_i.sample),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_sum_o  (push_sum),
    .push_len_o  (push_len)
  );

  trm_queue #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_sum_i (push_sum),
    .push_len_i (push_len),
    .count_o    (q_count),
    .valid_o    (q_valid),
    .sum_o      (q_sum),
    .len_o      (q_len),
    .pop_i      (pop)
  );

  trm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_sum_i     (q_sum),
    .q_len_i     (q_len),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .rms_o       (out_o.rms_level)
  );

endmodule

// ===== rtl/core/trm_front.sv =====
// Front end: item intake, holdoff timer, window framing and square accumulation.
module trm_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_WINDOW  = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  trm_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_kind_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_i,
  input  logic [trm_pkg::QUEUE_CNT_W-1:0]     q_count_i,
  output logic                                push_o,
  output logic [2*SAMPLE_BITS-2+$clog2(MAX_WINDOW):0] push_sum_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0]     push_len_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W  = SQ_W + $clog2(MAX_WINDOW);
  localparam int unsigned PEND_W = trm_pkg::QUEUE_CNT_W + 1;

  logic [trm_pkg::HOLDOFF_W-1:0] elapsed_q, elapsed_d;
  logic [LEN_W-1:0]              pos_q, pos_d;
  logic                          armed_q, armed_d;

  // stage A: magnitude of an armed sample
  logic                   a_vld_q, a_first_q, a_end_q;
  logic [SAMPLE_BITS-1:0] a_mag_q;
  logic [LEN_W-1:0]       a_len_q;
  // stage B: its square
  logic                   b_vld_q, b_first_q, b_end_q;
  logic [SQ_W-1:0]        b_sq_q;
  logic [LEN_W-1:0]       b_len_q;
  logic [SUM_W-1:0]       acc_q, acc_d;

  logic [LEN_W-1:0]       len_eff, pos_inc;
  logic [SAMPLE_BITS-1:0] smp_u, mag;
  logic [PROD_W-1:0]      prod;
  logic [PEND_W-1:0]      pending;
  logic                   accept, is_tick, first, arm_ok, armed_now, win_end, a_take;

  always_comb begin
    if (cfg_i.window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg_i.window_len) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(cfg_i.window_len);
    end
  end

  // Count every window end already in flight against the queue's free slots.
  assign pending = PEND_W'(q_count_i) + PEND_W'(a_vld_q & a_end_q)
                 + PEND_W'(b_vld_q & b_end_q);
  assign in_ready_o = pending < PEND_W'(trm_pkg::QUEUE_DEPTH);

  assign accept    = in_valid_i & in_ready_o;
  assign is_tick   = in_kind_i == trm_pkg::KIND_TICK;
  assign first     = pos_q == '0;
  assign arm_ok    = cfg_i.meter_enable && (elapsed_q > cfg_i.holdoff_ms);
  assign armed_now = first ? arm_ok : armed_q;
  assign pos_inc   = pos_q + LEN_W'(1);
  assign win_end   = pos_inc >= len_eff;
  assign smp_u     = in_sample_i;
  assign mag       = smp_u[SAMPLE_BITS-1] ? (~smp_u + 1'b1) : smp_u;
  assign a_take    = accept & ~is_tick & armed_now;

  always_comb begin
    elapsed_d = elapsed_q;
    pos_d     = pos_q;
    armed_d   = armed_q;
    if (accept) begin
      if (is_tick) begin
        if (elapsed_q != trm_pkg::ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end else begin
        if (first && arm_ok) begin
          elapsed_d = '0;
        end
        pos_d   = win_end ? '0 : pos_inc;
        armed_d = win_end ? 1'b0 : armed_now;
      end
    end
  end

  assign prod  = PROD_W'(a_mag_q) * PROD_W'(a_mag_q);
  assign acc_d = (b_first_q ? '0 : acc_q) + SUM_W'(b_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= trm_pkg::ELAPSED_MAX;
      pos_q     <= '0;
      armed_q   <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      pos_q     <= pos_d;
      armed_q   <= armed_d;
      a_vld_q   <= a_take;
      b_vld_q   <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_mag_q   <= mag;
      a_first_q <= first;
      a_end_q   <= win_end;
      a_len_q   <= len_eff;
    end
    if (a_vld_q) begin
      b_sq_q    <= prod[SQ_W-1:0];
      b_first_q <= a_first_q;
      b_end_q   <= a_end_q;
      b_len_q   <= a_len_q;
    end
    if (b_vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign push_o     = b_vld_q & b_end_q;
  assign push_sum_o = acc_d;
  assign push_len_o = b_len_q;

endmodule

// ===== rtl/core/trm_queue.sv =====
// Short queue of finished window sums between front and back.
module trm_queue #(
  parameter int unsigned SUM_W = 43,
  parameter int unsigned LEN_W = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [SUM_W-1:0]                push_sum_i,
  input  logic [LEN_W-1:0]                push_len_i,
  output logic [trm_pkg::QUEUE_CNT_W-1:0] count_o,
  output logic                            valid_o,
  output logic [SUM_W-1:0]                sum_o,
  output logic [LEN_W-1:0]                len_o,
  input  logic                            pop_i
);

  logic [SUM_W-1:0] sum_mem [trm_pkg::QUEUE_DEPTH];
  logic [LEN_W-1:0] len_mem [trm_pkg::QUEUE_DEPTH];
  logic [SUM_W-1:0] head_sum_q;
  logic [LEN_W-1:0] head_len_q;

  logic [trm_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q, rd_ptr_d;
  logic [trm_pkg::QUEUE_CNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  assign rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sum_mem[wr_ptr_q] <= push_sum_i;
      len_mem[wr_ptr_q] <= push_len_i;
    end
    // hold the head entry in a register; take the incoming item when it lands there
    if (push_i && (wr_ptr_q == rd_ptr_d)) begin
      head_sum_q <= push_sum_i;
      head_len_q <= push_len_i;
    end else begin
      head_sum_q <= sum_mem[rd_ptr_d];
      head_len_q <= len_mem[rd_ptr_d];
    end
  end

  assign count_o = count_q;
  assign valid_o = count_q != '0;
  assign sum_o   = head_sum_q;
  assign len_o   = head_len_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != trm_pkg::QUEUE_CNT_W'(trm_pkg::QUEUE_DEPTH)))
    else $error("window sum pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("window sum popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= trm_pkg::QUEUE_CNT_W'(trm_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/trm_back.sv =====
// Back end: sum / length by restoring division, then integer square root.
module trm_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_WINDOW  = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  logic [2*SAMPLE_BITS-2+$clog2(MAX_WINDOW):0] q_sum_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     q_len_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [SAMPLE_BITS-1:0]              rms_o
);

  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_WINDOW);
  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;
  localparam int unsigned SR_W  = SAMPLE_BITS + 1;
  localparam int unsigned ST_W  = SAMPLE_BITS + 3;
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0]       dq_q, dq_d;
  logic [LEN_W-1:0]       dlen_q, dlen_d;
  logic [LEN_W-1:0]       drem_q, drem_d;
  logic [RAD_W-1:0]       rad_q, rad_d;
  logic [SR_W-1:0]        srem_q, srem_d;
  logic [SAMPLE_BITS-1:0] root_q, root_d;
  logic                   out_vld_q, out_vld_d;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   load_out;

  logic [LEN_W:0]         div_try;
  logic                   div_ge;
  logic [ST_W-1:0]        sq_try, sq_trial;
  logic                   sq_ge;

  // One quotient bit per cycle.
  assign div_try = {drem_q, dq_q[SUM_W-1]};
  assign div_ge  = div_try >= {1'b0, dlen_q};

  // One root bit per cycle: bring down two radicand bits.
  assign sq_try   = {srem_q, rad_q[RAD_W-1 -: 2]};
  assign sq_trial = ST_W'({root_q, 2'b01});
  assign sq_ge    = sq_try >= sq_trial;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dq_d     = dq_q;
    dlen_d   = dlen_q;
    drem_d   = drem_q;
    rad_d    = rad_q;
    srem_d   = srem_q;
    root_d   = root_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          dq_d    = q_sum_i;
          dlen_d  = q_len_i;
          drem_d  = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        drem_d = div_ge ? LEN_W'(div_try - {1'b0, dlen_q}) : LEN_W'(div_try);
        dq_d   = {dq_q[SUM_W-2:0], div_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          // quotient never exceeds a full-scale square
          rad_d   = RAD_W'({dq_q[SQ_W-2:0], div_ge});
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_d = sq_ge ? SR_W'(sq_try - sq_trial) : SR_W'(sq_try);
        root_d = {root_q[SAMPLE_BITS-2:0], sq_ge};
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SAMPLE_BITS - 1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!out_vld_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    dlen_q <= dlen_d;
    drem_q <= drem_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    if (load_out) begin
      out_q <= root_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rms_o       = out_q;

endmodule

// ===== bench/throttled_rms_level_meter_test.sv =====
// Self-checking testbench for the throttled RMS level meter: directed, pressure and random traffic.
`timescale 1ns / 1ps

module throttled_rms_level_meter_test;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned MAX_WINDOW     = 4096;
  // margin for four queued windows plus handoff
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned TIMEOUT_CYCLES = 600_000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [trm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [trm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  trm_in_if  #(.SAMPLE_BITS(16)) item_in ();
  trm_out_if #(.SAMPLE_BITS(16)) level_out ();

  throttled_rms_level_meter #(
    .SAMPLE_BITS(16),
    .MAX_WINDOW (MAX_WINDOW)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (item_in),
    .out_o     (level_out),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Level meter state as the predictor sees it
  logic                          cfg_enable  = 1'b0;
  logic [trm_pkg::WIN_LEN_W-1:0] cfg_len     = trm_pkg::WIN_LEN_RESET;
  logic [trm_pkg::HOLDOFF_W-1:0] cfg_holdoff = trm_pkg::HOLDOFF_RESET;
  longint unsigned               lvl_sum     = 0;
  int unsigned                   lvl_pos     = 0;
  logic [trm_pkg::HOLDOFF_W-1:0] lvl_elapsed = trm_pkg::ELAPSED_MAX;
  logic                          lvl_armed   = 1'b0;

  logic [15:0]  rms_expected [$];
  int unsigned  error_count     = 0;
  int unsigned  items_sent      = 0;
  int unsigned  rx_hold_request = 0;
  int unsigned  tx_burst_left   = 0;
  bit           tx_gaps_on      = 1'b1;

  function automatic int unsigned active_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_WINDOW) return MAX_WINDOW;
    return 32'(cfg_len);
  endfunction

  function automatic logic [15:0] floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[15:0];
  endfunction

  function automatic void predict_level(logic kind, logic signed [15:0] smp);
    int              s32;
    longint unsigned mag;
    int unsigned     len;
    if (kind == trm_pkg::KIND_TICK) begin
      if (lvl_elapsed != trm_pkg::ELAPSED_MAX) lvl_elapsed++;
    end else begin
      len = active_len();
      // arm only at the first sample of a window
      if (lvl_pos == 0) begin
        lvl_armed = cfg_enable && (lvl_elapsed > cfg_holdoff);
        if (lvl_armed) begin
          lvl_elapsed = '0;
          lvl_sum     = 0;
        end
      end
      s32 = smp;
      if (s32 < 0) s32 = -s32;
      mag = s32;
      if (lvl_armed) lvl_sum += mag * mag;
      lvl_pos++;
      if (lvl_pos >= len) begin
        lvl_pos = 0;
        if (lvl_armed) begin
          lvl_armed = 1'b0;
          rms_expected.insert(rms_expected.size(), floor_sqrt(lvl_sum / len));
        end
      end
    end
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write all three registers; call only while the block is idle
  task automatic set_config(logic en, logic [trm_pkg::WIN_LEN_W-1:0] len,
                            logic [trm_pkg::HOLDOFF_W-1:0] hold);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= trm_pkg::CFG_METER_ENABLE;
    cfg_data_i <= {{(trm_pkg::CFG_DATA_W-1){1'b0}}, en};
    @(posedge clk_i);
    cfg_idx_i  <= trm_pkg::CFG_WINDOW_LEN;
    cfg_data_i <= trm_pkg::CFG_DATA_W'(len);
    @(posedge clk_i);
    cfg_idx_i  <= trm_pkg::CFG_HOLDOFF_MS;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_enable  = en;
    cfg_len     = len;
    cfg_holdoff = hold;
  endtask

  task automatic send_item(logic kind, logic signed [15:0] smp);
    int unsigned gap;
    item_in.valid  <= 1'b1;
    item_in.kind   <= kind;
    item_in.sample <= smp;
    do @(posedge clk_i); while (!item_in.ready);
    predict_level(kind, smp);
    items_sent++;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 40);
      if (tx_gaps_on) begin
        gap = $urandom_range(1, 6);
        item_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      tx_burst_left--;
    end
  endtask

  // Close any open window, send ticks, then one whole window of samples
  task automatic send_window(int unsigned ticks);
    int unsigned len;
    while (lvl_pos != 0) send_item(trm_pkg::KIND_SAMPLE, pick_sample());
    repeat (ticks) send_item(trm_pkg::KIND_TICK, 16'($urandom));
    len = active_len();
    repeat (len) send_item(trm_pkg::KIND_SAMPLE, pick_sample());
  endtask

  task automatic wait_drained();
    item_in.valid <= 1'b0;
    while (rms_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reset settings have metering off: nothing may come out
  task automatic test_disabled_meter();
    send_item(trm_pkg::KIND_SAMPLE, 16'sh8000);
    send_item(trm_pkg::KIND_TICK, 16'sh5A5A);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh0000);
  endtask

  // Elapsed count stays saturated; a holdoff of all ones never arms
  task automatic test_tick_saturation();
    wait_drained();
    set_config(1'b1, 13'd1, 16'hFFFF);
    send_item(trm_pkg::KIND_TICK, 16'shFFFF);
    send_item(trm_pkg::KIND_TICK, 16'sh0000);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh0064);
    wait_drained();
    set_config(1'b1, 13'd1, 16'hFFFE);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh8000);
  endtask

  // Zero length acts as one; a window right after arming is skipped
  task automatic test_sample_extremes();
    wait_drained();
    set_config(1'b1, 13'd0, 16'd0);
    send_item(trm_pkg::KIND_TICK, 16'sh1234);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh0000);
    send_item(trm_pkg::KIND_TICK, 16'sh8000);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh0000);
    send_item(trm_pkg::KIND_TICK, 16'sh7FFF);
    send_item(trm_pkg::KIND_SAMPLE, 16'shFFFF);
  endtask

  // Shrink the length and drop the enable inside an armed window
  task automatic test_length_change();
    wait_drained();
    set_config(1'b1, 13'd4, 16'd0);
    send_item(trm_pkg::KIND_TICK, 16'sh0000);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh8000);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh0005);
    wait_drained();
    set_config(1'b0, 13'd2, 16'd0);
    send_item(trm_pkg::KIND_SAMPLE, 16'sh8000);
  endtask

  // Hold the output off while one-sample windows pile up, then drain fully
  task automatic test_backpressure();
    wait_drained();
    set_config(1'b1, 13'd1, 16'd0);
    tx_gaps_on      = 1'b0;
    rx_hold_request = 1500;
    repeat (30) send_window(1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned                   first;
    int unsigned                   hold;
    int unsigned                   pick;
    logic                          en;
    logic [trm_pkg::WIN_LEN_W-1:0] len;
    for (int round = 0; round < 12; round++) begin
      en   = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 12)      len = 13'($urandom_range(1, 8));
      else if (pick < 17) len = 13'($urandom_range(9, 80));
      else if (pick < 19) len = '0;
      else                len = 13'($urandom_range(81, 300));
      pick = $urandom_range(0, 19);
      if (pick < 10)      hold = 0;
      else if (pick < 16) hold = $urandom_range(1, 4);
      else if (pick < 19) hold = $urandom_range(5, 30);
      else                hold = $urandom_range(0, 65535);
      wait_drained();
      set_config(en, len, 16'(hold));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      first = items_sent;
      while (items_sent - first < 100) begin
        if ($urandom_range(0, 4) != 0) begin
          // short holdoffs get the holdoff plus zero to two ticks: covers the equal boundary too
          send_window(hold <= 30 ? hold + $urandom_range(0, 2) : $urandom_range(0, 3));
        end else begin
          repeat ($urandom_range(1, 5)) send_item(1'($urandom_range(0, 1)), pick_sample());
        end
      end
    end
  endtask

  // Result receiver: random stall pattern plus requested long hold-offs
  initial begin : receiver
    int unsigned hold_left;
    int unsigned cycle;
    int unsigned mode;
    level_out.ready = 1'b0;
    hold_left = 0;
    cycle     = 0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      cycle++;
      if (cycle % 300 == 0) mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        level_out.ready <= 1'b0;
      end else begin
        case (mode)
          0: level_out.ready <= 1'b1;
          1: level_out.ready <= ($urandom_range(0, 3) != 0);
          2: level_out.ready <= ($urandom_range(0, 3) == 0);
          default: level_out.ready <= ((cycle % 9) < 5);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && level_out.valid && level_out.ready) begin
      if (rms_expected.size() == 0) begin
        $display("%0t: rms_level %0d arrived, expected none", $time, level_out.rms_level);
        error_count++;
      end else begin
        want = rms_expected.pop_front();
        if (level_out.rms_level !== want) begin
          $display("%0t: rms_level mismatch, expected %0d, actual %0d",
                   $time, want, level_out.rms_level);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("throttled_rms_level_meter_test: done, errors");
    $finish;
  end

  initial begin
    item_in.valid  = 1'b0;
    item_in.kind   = trm_pkg::KIND_SAMPLE;
    item_in.sample = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = trm_pkg::CFG_METER_ENABLE;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_meter();
    test_tick_saturation();
    test_sample_extremes();
    test_length_change();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("throttled_rms_level_meter_test: done, clean");
    end else begin
      $display("throttled_rms_level_meter_test: done, errors");
    end
    $finish;
  end

endmodule
